// File: hdl/orwl_pkg.sv
// shared types and constants for the overwriting ring with offset lookup
package orwl_pkg;

   localparam int ORWL_RING_DEPTH = 16;
   localparam int HANDLE_W = 32;
   localparam int LENGTH_W = 16;
   localparam int POS_W = 20;
   localparam int ENTRY_W = HANDLE_W + LENGTH_W;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 120;

   typedef struct packed {
      logic                find;
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
      logic [POS_W-1:0]    position;
   } orwl_request_type;

   typedef struct packed {
      logic                found;
      logic [HANDLE_W-1:0] hit_handle;
      logic [LENGTH_W-1:0] hit_length;
      logic [LENGTH_W-1:0] offset_in_entry;
      logic                evicted;
      logic [HANDLE_W-1:0] evicted_handle;
      logic [LENGTH_W-1:0] evicted_length;
   } orwl_result_type;

   typedef struct packed {
      logic idle;
      logic res_load;
   } orwl_status_type;

endpackage

// File: hdl/orwl_ram.sv
// generic single write port, single registered read port ram
module orwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/orwl_seq.sv
// ring pointers and sequencer: add with eviction, entry-by-entry find walk
module orwl_seq import orwl_pkg::*; #(
   parameter int RING_DEPTH = ORWL_RING_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  orwl_request_type              request,
   input  logic                          out_free,
   output orwl_status_type               status,
   output orwl_result_type               result,
   output logic                          mem_wr_en,
   output logic [$clog2(RING_DEPTH)-1:0] mem_wr_addr,
   output logic [ENTRY_W-1:0]            mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(RING_DEPTH)-1:0] mem_rd_addr,
   input  logic [ENTRY_W-1:0]            mem_rd_data
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int SUM_W = PTR_W + LENGTH_W;
   localparam int CMP_W = (SUM_W + 1 > POS_W) ? SUM_W + 1 : POS_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADD_WR = 3'd1;
   localparam logic [2:0] S_FIND   = 3'd2;
   localparam logic [2:0] S_DONE   = 3'd3;

   logic [2:0]          state_ff, state_in;
   logic [PTR_W-1:0]    write_ff, write_in;
   logic [PTR_W-1:0]    oldest_ff, oldest_in;
   logic                full_ff, full_in;
   logic [PTR_W-1:0]    idx_ff, idx_in;
   logic [PTR_W:0]      step_ff, step_in;
   logic [PTR_W:0]      count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [HANDLE_W-1:0] new_handle_ff, new_handle_in;
   logic [LENGTH_W-1:0] new_length_ff, new_length_in;
   orwl_result_type     res_ff, res_in;

   logic [PTR_W:0]      count_now;
   logic [CMP_W-1:0]    end_pos;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    rel_pos;
   logic                res_load;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
      next_slot = (s == PTR_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   always_comb begin
      if (full_ff) begin
         count_now = (PTR_W+1)'(RING_DEPTH);
      end else if (write_ff >= oldest_ff) begin
         count_now = {1'b0, write_ff} - {1'b0, oldest_ff};
      end else begin
         count_now = {1'b0, write_ff} + (PTR_W+1)'(RING_DEPTH) - {1'b0, oldest_ff};
      end
   end

   // running end of the current entry in the concatenated string
   assign end_pos = CMP_W'(sum_ff) + CMP_W'(mem_rd_data[LENGTH_W-1:0]);
   assign pos_ext = CMP_W'(pos_ff);
   assign rel_pos = pos_ext - CMP_W'(sum_ff);

   always_comb begin
      state_in      = state_ff;
      write_in      = write_ff;
      oldest_in     = oldest_ff;
      full_in       = full_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      pos_in        = pos_ff;
      new_handle_in = new_handle_ff;
      new_length_in = new_length_ff;
      res_in        = res_ff;
      res_load      = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = write_ff;
      mem_wr_data   = {new_handle_ff, new_length_ff};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = oldest_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_in = '0;
               if (!request.find) begin
                  if (full_ff) begin
                     // fetch the oldest entry before its slot is rewritten
                     new_handle_in = request.handle;
                     new_length_in = request.length;
                     mem_rd_en     = 1'b1;
                     state_in      = S_ADD_WR;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = {request.handle, request.length};
                     write_in    = next_slot(write_ff);
                     full_in     = (next_slot(write_ff) == oldest_ff);
                     state_in    = S_DONE;
                  end
               end else begin
                  pos_in    = request.position;
                  count_in  = count_now;
                  idx_in    = oldest_ff;
                  step_in   = '0;
                  sum_in    = '0;
                  mem_rd_en = 1'b1;
                  state_in  = (count_now == '0) ? S_DONE : S_FIND;
               end
            end
         end
         S_ADD_WR: begin
            mem_wr_en             = 1'b1;
            res_in.evicted        = 1'b1;
            res_in.evicted_handle = mem_rd_data[ENTRY_W-1:LENGTH_W];
            res_in.evicted_length = mem_rd_data[LENGTH_W-1:0];
            write_in              = next_slot(write_ff);
            oldest_in             = next_slot(oldest_ff);
            full_in               = 1'b1;
            state_in              = S_DONE;
         end
         S_FIND: begin
            if (pos_ext < end_pos) begin
               res_in.found           = 1'b1;
               res_in.hit_handle      = mem_rd_data[ENTRY_W-1:LENGTH_W];
               res_in.hit_length      = mem_rd_data[LENGTH_W-1:0];
               res_in.offset_in_entry = rel_pos[LENGTH_W-1:0];
               state_in               = S_DONE;
            end else if (step_ff + 1'b1 == count_ff) begin
               state_in = S_DONE;
            end else begin
               step_in     = step_ff + 1'b1;
               idx_in      = next_slot(idx_ff);
               sum_in      = end_pos[SUM_W-1:0];
               mem_rd_en   = 1'b1;
               mem_rd_addr = next_slot(idx_ff);
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         write_ff  <= '0;
         oldest_ff <= '0;
         full_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         write_ff  <= write_in;
         oldest_ff <= oldest_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      count_ff      <= count_in;
      sum_ff        <= sum_in;
      pos_ff        <= pos_in;
      new_handle_ff <= new_handle_in;
      new_length_ff <= new_length_in;
      res_ff        <= res_in;
   end

   assign status.idle     = (state_ff == S_IDLE);
   assign status.res_load = res_load;
   assign result          = res_ff;

   a_full_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (write_ff == oldest_ff))
      else $error("ring full but write and oldest pointers differ");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> (count_ff != '0) && (step_ff < count_ff))
      else $error("find walk running past stored entries");

   a_load_then_idle: assert property (@(posedge clock) disable iff (reset)
      res_load |=> (state_ff == S_IDLE))
      else $error("sequencer not idle after handing over a result");

   a_no_write_in_find: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> !mem_wr_en)
      else $error("ring written during a find walk");

endmodule

// File: hdl/overwriting_ring_with_offset_lookup.sv
// an add writes its slot, first reading out the oldest entry when it is evicted; a find walks from the oldest
// a find reads one stored entry per cycle through the single ram read port
// one beat is worked on at a time: the next is taken once the sequencer is idle,
// while the previous result may still wait in the output register
// reset empties the ring (pointers and full flag cleared); entry storage is not
// cleared, as no stored value is used before its slot has been written
module overwriting_ring_with_offset_lookup import orwl_pkg::*; #(
   parameter int RING_DEPTH = ORWL_RING_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // new_handle[31:0], new_length[47:32], byte_position[67:48], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found[0], hit_handle[32:1], hit_length[48:33], offset_in_entry[64:49],
   // evicted[65], evicted_handle[97:66], evicted_length[113:98], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PTR_W = $clog2(RING_DEPTH);

   orwl_request_type     request;
   orwl_status_type      status;
   orwl_result_type      result;
   logic                 start;
   logic                 out_free;
   logic                 mem_wr_en;
   logic [PTR_W-1:0]     mem_wr_addr;
   logic [ENTRY_W-1:0]   mem_wr_data;
   logic                 mem_rd_en;
   logic [PTR_W-1:0]     mem_rd_addr;
   logic [ENTRY_W-1:0]   mem_rd_data;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign request.find     = req_tuser;
   assign request.handle   = req_tdata[HANDLE_W-1:0];
   assign request.length   = req_tdata[HANDLE_W+LENGTH_W-1:HANDLE_W];
   assign request.position = req_tdata[HANDLE_W+LENGTH_W+POS_W-1:HANDLE_W+LENGTH_W];

   assign req_tready = status.idle;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   orwl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   orwl_seq #(
      .RING_DEPTH (RING_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .request     (request),
      .out_free    (out_free),
      .status      (status),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // output register holds a finished beat while the sequencer moves on
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      if (status.res_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = {6'b0,
                          result.evicted_length, result.evicted_handle, result.evicted,
                          result.offset_in_entry, result.hit_length, result.hit_handle,
                          result.found};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/tb.sv
// testbench for the overwriting ring with offset lookup, checked beat by beat against a predictor
`timescale 1ns / 1ps

module tb;
   import orwl_pkg::*;

   localparam bit MODE_ADD = 1'b0;
   localparam bit MODE_FIND = 1'b1;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 80;
   localparam int ITEMS_PER_PHASE = 100;

   // predicts every result from its own copy of the ring and checks the beats in order
   class ring_scoreboard;
      bit [HANDLE_W-1:0] handles[ORWL_RING_DEPTH];
      bit [LENGTH_W-1:0] lengths[ORWL_RING_DEPTH];
      int write_slot;
      int oldest_slot;
      bit full;
      orwl_result_type expected_q[$];
      int errors;
      int checked;
      int adds;
      int finds;
      int evictions;
      int hits;
      int misses;

      function new();
         foreach (handles[i]) begin
            handles[i] = '0;
            lengths[i] = '0;
         end
         write_slot = 0;
         oldest_slot = 0;
         full = 1'b0;
         errors = 0;
         checked = 0;
         adds = 0;
         finds = 0;
         evictions = 0;
         hits = 0;
         misses = 0;
      endfunction

      function int entry_count();
         if (full)
            return ORWL_RING_DEPTH;
         return (write_slot + ORWL_RING_DEPTH - oldest_slot) % ORWL_RING_DEPTH;
      endfunction

      function int unsigned stored_bytes();
         int unsigned total;
         total = 0;
         for (int i = 0; i < entry_count(); i++)
            total += lengths[(oldest_slot + i) % ORWL_RING_DEPTH];
         return total;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(bit find_op, bit [HANDLE_W-1:0] handle,
                                 bit [LENGTH_W-1:0] length, bit [POS_W-1:0] pos);
         orwl_result_type r;
         int count;
         int idx;
         int unsigned sum;
         bit hit;
         r = '0;
         if (find_op == MODE_ADD) begin
            adds++;
            if (full) begin
               r.evicted = 1'b1;
               r.evicted_handle = handles[oldest_slot];
               r.evicted_length = lengths[oldest_slot];
               evictions++;
            end
            handles[write_slot] = handle;
            lengths[write_slot] = length;
            write_slot = (write_slot + 1) % ORWL_RING_DEPTH;
            if (full)
               oldest_slot = (oldest_slot + 1) % ORWL_RING_DEPTH;
            full = (write_slot == oldest_slot);
         end else begin
            finds++;
            count = entry_count();
            sum = 0;
            hit = 1'b0;
            // zero-length entries hold no bytes, so the compare never selects them
            for (int i = 0; i < count && !hit; i++) begin
               idx = (oldest_slot + i) % ORWL_RING_DEPTH;
               if (pos < sum + lengths[idx]) begin
                  hit = 1'b1;
                  r.found = 1'b1;
                  r.hit_handle = handles[idx];
                  r.hit_length = lengths[idx];
                  r.offset_in_entry = LENGTH_W'(pos - sum);
               end
               sum += lengths[idx];
            end
            if (hit)
               hits++;
            else
               misses++;
         end
         expected_q.push_back(r);
      endfunction

      task report(string what, logic [HANDLE_W-1:0] got, logic [HANDLE_W-1:0] want);
         $display("[%0t] result %0d: %s got %h expected %h", $time, checked, what, got, want);
         errors++;
      endtask

      task check_result(logic [RSP_DATA_W-1:0] beat);
         orwl_result_type got;
         orwl_result_type want;
         got.found = beat[0];
         got.hit_handle = beat[32:1];
         got.hit_length = beat[48:33];
         got.offset_in_entry = beat[64:49];
         got.evicted = beat[65];
         got.evicted_handle = beat[97:66];
         got.evicted_length = beat[113:98];
         if (expected_q.size() == 0) begin
            report("beat with nothing expected", beat[31:0], '0);
         end else begin
            want = expected_q.pop_front();
            if (got.found !== want.found)
               report("found", got.found, want.found);
            if (got.hit_handle !== want.hit_handle)
               report("hit_handle", got.hit_handle, want.hit_handle);
            if (got.hit_length !== want.hit_length)
               report("hit_length", got.hit_length, want.hit_length);
            if (got.offset_in_entry !== want.offset_in_entry)
               report("offset_in_entry", got.offset_in_entry, want.offset_in_entry);
            if (got.evicted !== want.evicted)
               report("evicted", got.evicted, want.evicted);
            if (got.evicted_handle !== want.evicted_handle)
               report("evicted_handle", got.evicted_handle, want.evicted_handle);
            if (got.evicted_length !== want.evicted_length)
               report("evicted_length", got.evicted_length, want.evicted_length);
         end
         checked++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ring_scoreboard sb;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_request;
   int hold_left;
   int quiet_cycles;

   overwriting_ring_with_offset_lookup DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus a long hold-off on request so the ring backs up
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // result checking and the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task send_item(bit mode, bit [HANDLE_W-1:0] handle, bit [LENGTH_W-1:0] length,
                  bit [POS_W-1:0] pos);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = mode;
      req_tdata = '0;
      req_tdata[31:0] = handle;
      req_tdata[47:32] = length;
      req_tdata[67:48] = pos;
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(mode, handle, length, pos);
   endtask

   task send_random_item();
      int sel;
      int unsigned total;
      bit [LENGTH_W-1:0] length;
      bit [POS_W-1:0] pos;
      sel = $urandom_range(99);
      if (sel < 35) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: length = LENGTH_W'($urandom_range(1, 64));
            6: length = '0;
            7: length = '1;
            default: length = LENGTH_W'($urandom);
         endcase
         send_item(MODE_ADD, $urandom, length, POS_W'($urandom));
      end else begin
         total = sb.stored_bytes();
         sel = $urandom_range(99);
         if (total > 0 && sel < 70)
            pos = POS_W'($urandom_range(0, total - 1));
         else if (sel < 85)
            pos = (total + 3 > 20'hFFFFF) ? 20'hFFFFF : POS_W'(total + $urandom_range(0, 3));
         else
            pos = POS_W'($urandom_range(0, 20'hFFFFF));
         send_item(MODE_FIND, $urandom, LENGTH_W'($urandom), pos);
      end
   endtask

   initial begin
      int unsigned total;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_ADD;
      rsp_tready = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty ring, with the add-only fields at their extremes
      send_item(MODE_FIND, '1, '1, '0);
      send_item(MODE_FIND, '0, '0, '1);
      // fill the ring with extreme handles, zero lengths and full lengths, then evict
      for (int i = 0; i < ORWL_RING_DEPTH + 1; i++) begin
         case (i)
            0: send_item(MODE_ADD, '0, '1, '1);
            1: send_item(MODE_ADD, '1, '0, '0);
            2: send_item(MODE_ADD, $urandom, 16'd1, POS_W'($urandom));
            3: send_item(MODE_ADD, $urandom, '0, POS_W'($urandom));
            15, 16: send_item(MODE_ADD, $urandom, '1, POS_W'($urandom));
            default: send_item(MODE_ADD, $urandom, LENGTH_W'($urandom_range(1, 40)),
                               POS_W'($urandom));
         endcase
      end
      // oldest entry is now zero length, so position zero lands past it
      total = sb.stored_bytes();
      send_item(MODE_FIND, '0, '0, '0);
      send_item(MODE_FIND, '0, '0, 20'd1);
      send_item(MODE_FIND, '0, '0, POS_W'(total - 1));
      send_item(MODE_FIND, '0, '0, POS_W'(total));
      send_item(MODE_FIND, '0, '0, '1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 69;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 69;
            end
            default: begin
               sender_idle_pct = 13;
               receiver_stall_pct = 13;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 0 && n == 10)
               hold_request = 1'b1;
            send_random_item();
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (ORWL_RING_DEPTH + 8) @(posedge clock);

      $display("covered %0d adds with %0d evictions and %0d finds (%0d hits, %0d misses)",
               sb.adds, sb.evictions, sb.finds, sb.hits, sb.misses);
      $display("%0d results checked across four handshake phases and one long output hold-off",
               sb.checked);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
